### rtl/bwss_pkg.sv
// shared constants, types and helpers of the bidirectional wrapping substring search
`timescale 1ns / 1ps

package bwss_pkg;

    localparam int HAY_DEPTH  = 4096;
    localparam int NEEDLE_MAX = 64;

    localparam int HAY_AW = (HAY_DEPTH > 1) ? $clog2(HAY_DEPTH) : 1;
    localparam int HLEN_W = $clog2(HAY_DEPTH + 1);
    localparam int NDL_AW = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
    localparam int NLEN_W = $clog2(NEEDLE_MAX + 1);

    // fixed field widths of the stream items
    localparam int POS_W    = 12;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;

    // position arithmetic wide enough for both start_pos and haystack lengths
    localparam int SW = (HLEN_W > POS_W) ? HLEN_W : POS_W;

    localparam logic [1:0] CMD_LOAD_NDL = 2'd0;
    localparam logic [1:0] CMD_LOAD_HAY = 2'd1;
    localparam logic [1:0] CMD_SEARCH   = 2'd2;

    localparam logic [7:0] ASCII_UP_A = 8'h41;
    localparam logic [7:0] ASCII_UP_Z = 8'h5A;
    localparam logic [7:0] FOLD_OFS   = 8'd32;

    typedef struct packed {
        logic accept;
        logic init;
        logic p2_begin;
        logic idx_inc;
        logic cand_step;
        logic set_hit;
        logic set_miss;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic triv_miss;
        logic p1_empty;
        logic p2_ok;
        logic byte_eq;
        logic idx_last;
        logic cand_end;
        logic out_free;
    } dp_stat_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= ASCII_UP_A && c <= ASCII_UP_Z) begin
            r = c + FOLD_OFS;
        end
        return r;
    endfunction

endpackage

### rtl/bidirectional_wrapping_substring_search.sv
// top level: substring search over loaded needle and haystack strings
//
// input stream items carry a command in s_tuser: load a needle byte, load a
// haystack byte, or request a search. s_tlast on a load marks the final byte
// of that string; the next load of the same kind starts a new string. bytes
// beyond capacity are dropped. a search item yields one result item on the
// master side: m_tuser is the found flag, m_tdata the match start (0 if none).
// loads give no result. a search runs a setup step (S_INIT), then, unless it
// misses at setup, a read step (S_READ) and a compare step (S_CMP) for each
// needle byte compared at each candidate start, and ends in S_FIN, which loads
// the output register. one haystack and one needle read are made per compare.
// s_tready is high only while no search is running. a finished result sits
// in an output register; a stalled receiver holds m_tvalid and the payload,
// and a further search waits in its last step until that register frees.
// reset empties and closes both strings and drops any pending result; the
// byte stores themselves are not cleared.
`timescale 1ns / 1ps

module bidirectional_wrapping_substring_search (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // data_byte[7:0], start_pos[19:8], search_forward[20], wrap_around[21],
    // case_fold[22], zero[23]
    input  logic [bwss_pkg::S_DATA_W-1:0] s_tdata,
    // cmd[1:0]
    input  logic [1:0]  s_tuser,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // match_pos[11:0], zero[15:12]
    output logic [bwss_pkg::M_DATA_W-1:0] m_tdata,
    // found[0]
    output logic        m_tuser
);
    import bwss_pkg::*;

    ctrl_cmd_t        cmd;
    dp_stat_t         stat;
    logic [POS_W-1:0] m_pos;

    bwss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_cmd    (s_tuser),
        .s_ready  (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bwss_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_cmd    (s_tuser),
        .s_byte   (s_tdata[7:0]),
        .s_last   (s_tlast),
        .s_start  (s_tdata[19:8]),
        .s_fwd    (s_tdata[20]),
        .s_wrap   (s_tdata[21]),
        .s_fold   (s_tdata[22]),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_found  (m_tuser),
        .m_pos    (m_pos)
    );

    assign m_tdata = {{(M_DATA_W - POS_W){1'b0}}, m_pos};

endmodule

### rtl/bwss_ctrl.sv
// search sequencer state machine
`timescale 1ns / 1ps

module bwss_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic [1:0]          s_cmd,
    output logic                s_ready,
    input  bwss_pkg::dp_stat_t  stat,
    output bwss_pkg::ctrl_cmd_t cmd
);
    import bwss_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_INIT = 5'b00010,
        S_READ = 5'b00100,
        S_CMP  = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_tvalid && s_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.accept = accept;
        case (state_reg)
            S_IDLE: begin
                if (accept && s_cmd == CMD_SEARCH) begin
                    state_next = S_INIT;
                end
            end
            S_INIT: begin
                if (stat.triv_miss) begin
                    cmd.set_miss = 1'b1;
                    state_next   = S_FIN;
                end else if (stat.p1_empty) begin
                    if (stat.p2_ok) begin
                        cmd.p2_begin = 1'b1;
                        state_next   = S_READ;
                    end else begin
                        cmd.set_miss = 1'b1;
                        state_next   = S_FIN;
                    end
                end else begin
                    cmd.init   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                if (stat.byte_eq) begin
                    if (stat.idx_last) begin
                        cmd.set_hit = 1'b1;
                        state_next  = S_FIN;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_READ;
                    end
                end else if (!stat.cand_end) begin
                    cmd.cand_step = 1'b1;
                    state_next    = S_READ;
                end else if (stat.p2_ok) begin
                    cmd.p2_begin = 1'b1;
                    state_next   = S_READ;
                end else begin
                    cmd.set_miss = 1'b1;
                    state_next   = S_FIN;
                end
            end
            S_FIN: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/bwss_dpath.sv
// string stores, lengths, candidate walk and result register
`timescale 1ns / 1ps

module bwss_dpath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bwss_pkg::ctrl_cmd_t         cmd,
    output bwss_pkg::dp_stat_t          stat,
    input  logic [1:0]                  s_cmd,
    input  logic [7:0]                  s_byte,
    input  logic                        s_last,
    input  logic [bwss_pkg::POS_W-1:0]  s_start,
    input  logic                        s_fwd,
    input  logic                        s_wrap,
    input  logic                        s_fold,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_found,
    output logic [bwss_pkg::POS_W-1:0]  m_pos
);
    import bwss_pkg::*;

    logic [7:0] hay_mem [HAY_DEPTH];
    logic [7:0] ndl_mem [NEEDLE_MAX];

    logic [7:0] hay_rd_reg, ndl_rd_reg;

    logic [HLEN_W-1:0] hlen_reg, hlen_next;
    logic              hclosed_reg, hclosed_next;
    logic [NLEN_W-1:0] nlen_reg, nlen_next;
    logic              nclosed_reg, nclosed_next;

    logic              hay_we, ndl_we;
    logic [HAY_AW-1:0] hay_waddr, hay_raddr;
    logic [NDL_AW-1:0] ndl_waddr;

    // search context
    logic [POS_W-1:0]  from_reg, from_next;
    logic              fwd_reg, fwd_next;
    logic              wrap_reg, wrap_next;
    logic              fold_reg, fold_next;
    logic              empty_reg, empty_next;
    logic [SW-1:0]     maxstart_reg, maxstart_next;
    logic [SW-1:0]     start_reg, start_next;
    logic [SW-1:0]     cand_reg, cand_next;
    logic [SW-1:0]     end_reg, end_next;
    logic [NDL_AW-1:0] idx_reg, idx_next;
    logic              pass2_reg, pass2_next;

    logic              res_found_reg, res_found_next;
    logic [POS_W-1:0]  res_pos_reg, res_pos_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_found_reg, m_found_next;
    logic [POS_W-1:0]  m_pos_reg, m_pos_next;

    logic [SW-1:0]     from_w, clamp, from_m1, fwd_end2;
    logic [7:0]        hay_cmp, ndl_cmp;
    logic              is_ndl, is_hay, is_srch;

    assign is_ndl  = cmd.accept && s_cmd == CMD_LOAD_NDL;
    assign is_hay  = cmd.accept && s_cmd == CMD_LOAD_HAY;
    assign is_srch = cmd.accept && s_cmd == CMD_SEARCH;

    // a load into a closed string restarts it at position zero
    assign ndl_we    = is_ndl && (nclosed_reg || nlen_reg < NLEN_W'(NEEDLE_MAX));
    assign ndl_waddr = nclosed_reg ? '0 : nlen_reg[NDL_AW-1:0];
    assign hay_we    = is_hay && (hclosed_reg || hlen_reg < HLEN_W'(HAY_DEPTH));
    assign hay_waddr = hclosed_reg ? '0 : hlen_reg[HAY_AW-1:0];

    assign hay_raddr = HAY_AW'(cand_reg + SW'(idx_reg));

    always_ff @(posedge aclk) begin
        if (hay_we) begin
            hay_mem[hay_waddr] <= s_byte;
        end
        hay_rd_reg <= hay_mem[hay_raddr];
    end

    always_ff @(posedge aclk) begin
        if (ndl_we) begin
            ndl_mem[ndl_waddr] <= s_byte;
        end
        ndl_rd_reg <= ndl_mem[idx_reg];
    end

    assign from_w   = SW'(from_reg);
    assign clamp    = (from_w < maxstart_reg) ? from_w : maxstart_reg;
    assign from_m1  = from_w - SW'(1);
    assign fwd_end2 = (from_m1 < maxstart_reg) ? from_m1 : maxstart_reg;

    assign hay_cmp = fold_reg ? fold_byte(hay_rd_reg) : hay_rd_reg;
    assign ndl_cmp = fold_reg ? fold_byte(ndl_rd_reg) : ndl_rd_reg;

    always_comb begin
        stat.triv_miss = empty_reg;
        stat.p1_empty  = fwd_reg && (from_w > maxstart_reg);
        stat.p2_ok     = wrap_reg && !pass2_reg &&
                         (fwd_reg ? (from_reg != '0) : (start_reg < maxstart_reg));
        stat.byte_eq   = (hay_cmp == ndl_cmp);
        stat.idx_last  = (NLEN_W'(idx_reg) + NLEN_W'(1)) == nlen_reg;
        stat.cand_end  = (cand_reg == end_reg);
        stat.out_free  = !m_valid_reg || m_ready;
    end

    always_comb begin
        hlen_next     = hlen_reg;
        hclosed_next  = hclosed_reg;
        nlen_next     = nlen_reg;
        nclosed_next  = nclosed_reg;
        from_next     = from_reg;
        fwd_next      = fwd_reg;
        wrap_next     = wrap_reg;
        fold_next     = fold_reg;
        empty_next    = empty_reg;
        maxstart_next = maxstart_reg;
        start_next    = start_reg;
        cand_next     = cand_reg;
        end_next      = end_reg;
        idx_next      = idx_reg;
        pass2_next    = pass2_reg;
        res_found_next = res_found_reg;
        res_pos_next  = res_pos_reg;
        m_valid_next  = m_valid_reg;
        m_found_next  = m_found_reg;
        m_pos_next    = m_pos_reg;

        if (is_ndl) begin
            if (nclosed_reg) begin
                nlen_next = NLEN_W'(1);
            end else if (nlen_reg < NLEN_W'(NEEDLE_MAX)) begin
                nlen_next = nlen_reg + NLEN_W'(1);
            end
            nclosed_next = s_last;
        end
        if (is_hay) begin
            if (hclosed_reg) begin
                hlen_next = HLEN_W'(1);
            end else if (hlen_reg < HLEN_W'(HAY_DEPTH)) begin
                hlen_next = hlen_reg + HLEN_W'(1);
            end
            hclosed_next = s_last;
        end
        if (is_srch) begin
            from_next     = s_start;
            fwd_next      = s_fwd;
            wrap_next     = s_wrap;
            fold_next     = s_fold;
            empty_next    = (nlen_reg == '0) || (HLEN_W'(nlen_reg) > hlen_reg);
            maxstart_next = SW'(hlen_reg - HLEN_W'(nlen_reg));
            pass2_next    = 1'b0;
        end
        if (cmd.init) begin
            start_next = clamp;
            cand_next  = fwd_reg ? from_w : clamp;
            end_next   = fwd_reg ? maxstart_reg : '0;
            idx_next   = '0;
            pass2_next = 1'b0;
        end
        if (cmd.p2_begin) begin
            cand_next  = fwd_reg ? '0 : maxstart_reg;
            end_next   = fwd_reg ? fwd_end2 : start_reg + SW'(1);
            idx_next   = '0;
            pass2_next = 1'b1;
        end
        if (cmd.idx_inc) begin
            idx_next = idx_reg + NDL_AW'(1);
        end
        if (cmd.cand_step) begin
            cand_next = fwd_reg ? cand_reg + SW'(1) : cand_reg - SW'(1);
            idx_next  = '0;
        end
        if (cmd.set_hit) begin
            res_found_next = 1'b1;
            res_pos_next   = POS_W'(cand_reg);
        end
        if (cmd.set_miss) begin
            res_found_next = 1'b0;
            res_pos_next   = '0;
        end

        // output register: taken item leaves, a finished search enters
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
            m_found_next = res_found_reg;
            m_pos_next   = res_pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hlen_reg    <= '0;
            hclosed_reg <= 1'b1;
            nlen_reg    <= '0;
            nclosed_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            hlen_reg    <= hlen_next;
            hclosed_reg <= hclosed_next;
            nlen_reg    <= nlen_next;
            nclosed_reg <= nclosed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        from_reg      <= from_next;
        fwd_reg       <= fwd_next;
        wrap_reg      <= wrap_next;
        fold_reg      <= fold_next;
        empty_reg     <= empty_next;
        maxstart_reg  <= maxstart_next;
        start_reg     <= start_next;
        cand_reg      <= cand_next;
        end_reg       <= end_next;
        idx_reg       <= idx_next;
        pass2_reg     <= pass2_next;
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        m_found_reg   <= m_found_next;
        m_pos_reg     <= m_pos_next;
    end

    assign m_valid = m_valid_reg;
    assign m_found = m_found_reg;
    assign m_pos   = m_pos_reg;

endmodule
